[rtl/dcmf_pkg.sv]
`timescale 1ns / 1ps

package dcmf_pkg;

    // FIFO geometry
    localparam int FIFO_DEPTH = 16;
    localparam int WORD_BITS  = 32;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    // Bus word widths
    localparam int DATA_W   = 32;
    localparam int OPCODE_W = 3;
    localparam int LANE_W   = 2;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [PTR_W-1:0]     ptr_t;

    // Access codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_RD_CTRL = 3'd0,
        OP_WR_CTRL = 3'd1,
        OP_SEND    = 3'd2,
        OP_RECV    = 3'd3,
        OP_RD_SYNC = 3'd4,
        OP_WR_SYNC = 3'd5
    } op_t;

    // Byte lanes
    localparam int LANE_LO = 0;
    localparam int LANE_HI = 1;

    // Control word bit positions
    localparam int CTL_OWN_EMPTY = 0;
    localparam int CTL_OWN_FULL  = 1;
    localparam int CTL_SENT_IE   = 2;
    localparam int CTL_CLEAR     = 3;
    localparam int CTL_PEER_EMPTY = 8;
    localparam int CTL_PEER_FULL = 9;
    localparam int CTL_RECV_IE   = 10;
    localparam int CTL_ERROR     = 14;
    localparam int CTL_ENABLE    = 15;

    // Sync word bit positions
    localparam int SYNC_PEER_LSB = 0;
    localparam int SYNC_OWN_LSB  = 8;
    localparam int SYNC_IRQ      = 13;
    localparam int SYNC_ENABLE   = 14;
    localparam int NIBBLE_W      = 4;

    // Captured bus access
    typedef struct packed {
        logic                cpu_side;
        logic [OPCODE_W-1:0] opcode;
        logic [DATA_W-1:0]   write_data;
        logic [LANE_W-1:0]   lane_mask;
    } req_t;

    // Result of one access
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [1:0]        irq_sent_mask;
        logic [1:0]        irq_recv_mask;
        logic [1:0]        irq_sync_mask;
    } rsp_t;

    // Commands into one send FIFO
    typedef struct packed {
        logic  clear;
        logic  push;
        logic  pop;
        word_t data;
    } fifo_ctl_t;

    // Status out of one send FIFO
    typedef struct packed {
        logic  empty;
        logic  full;
        logic  last;
        word_t head;
    } fifo_sts_t;

    // Advance a pointer modulo the FIFO depth
    function automatic ptr_t bump(input ptr_t p);
        return (p == ptr_t'(FIFO_DEPTH - 1)) ? '0 : ptr_t'(p + ptr_t'(1));
    endfunction

    // Fit a bus word into a stored word
    function automatic word_t to_word(input logic [DATA_W-1:0] d);
        logic [63:0] wide;
        wide = 64'(d);
        return wide[WORD_BITS-1:0];
    endfunction

    // Fit a stored word onto the bus
    function automatic logic [DATA_W-1:0] from_word(input word_t w);
        logic [63:0] wide;
        wide = 64'(w);
        return wide[DATA_W-1:0];
    endfunction

endpackage

[rtl/dcmf_req_if.sv]
`timescale 1ns / 1ps

interface dcmf_req_if;
    logic                          valid;
    logic                          ready;
    logic                          cpu_side;
    logic [dcmf_pkg::OPCODE_W-1:0] opcode;
    logic [dcmf_pkg::DATA_W-1:0]   write_data;
    logic [dcmf_pkg::LANE_W-1:0]   lane_mask;

    modport source (output valid, cpu_side, opcode, write_data, lane_mask, input ready);
    modport sink   (input valid, cpu_side, opcode, write_data, lane_mask, output ready);
endinterface

[rtl/dcmf_rsp_if.sv]
`timescale 1ns / 1ps

interface dcmf_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [dcmf_pkg::DATA_W-1:0] read_data;
    logic [1:0]                  irq_sent_mask;
    logic [1:0]                  irq_recv_mask;
    logic [1:0]                  irq_sync_mask;

    modport source (output valid, read_data, irq_sent_mask, irq_recv_mask, irq_sync_mask,
                    input ready);
    modport sink   (input valid, read_data, irq_sent_mask, irq_recv_mask, irq_sync_mask,
                    output ready);
endinterface

[rtl/dcmf_fifo.sv]
`timescale 1ns / 1ps

module dcmf_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  dcmf_pkg::fifo_ctl_t ctl,
    output dcmf_pkg::fifo_sts_t sts
);

    dcmf_pkg::word_t words_reg [dcmf_pkg::FIFO_DEPTH];
    dcmf_pkg::ptr_t  rd_ptr_reg;
    dcmf_pkg::ptr_t  wr_ptr_reg;
    logic            empty_reg;
    logic            full_reg;

    dcmf_pkg::ptr_t  rd_ptr_next;
    dcmf_pkg::ptr_t  wr_ptr_next;
    logic            empty_next;
    logic            full_next;
    dcmf_pkg::ptr_t  rd_bump;
    dcmf_pkg::ptr_t  wr_bump;

    assign rd_bump = dcmf_pkg::bump(rd_ptr_reg);
    assign wr_bump = dcmf_pkg::bump(wr_ptr_reg);

    // Compute pointer and flag updates
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        empty_next  = empty_reg;
        full_next   = full_reg;
        if (ctl.clear)
        begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            empty_next  = 1'b1;
            full_next   = 1'b0;
        end
        else if (ctl.push)
        begin
            wr_ptr_next = wr_bump;
            empty_next  = 1'b0;
            full_next   = (wr_bump == rd_ptr_reg);
        end
        else if (ctl.pop)
        begin
            rd_ptr_next = rd_bump;
            full_next   = 1'b0;
            empty_next  = (rd_bump == wr_ptr_reg);
        end
    end

    // Hold pointers and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            empty_reg  <= 1'b1;
            full_reg   <= 1'b0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            empty_reg  <= empty_next;
            full_reg   <= full_next;
        end
    end

    // Store words; zero them all on reset and on clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dcmf_pkg::FIFO_DEPTH; i++)
            begin
                words_reg[i] <= '0;
            end
        end
        else if (ctl.clear)
        begin
            for (int i = 0; i < dcmf_pkg::FIFO_DEPTH; i++)
            begin
                words_reg[i] <= '0;
            end
        end
        else if (ctl.push)
        begin
            words_reg[wr_ptr_reg] <= ctl.data;
        end
    end

    // Report status and head word
    assign sts.empty = empty_reg;
    assign sts.full  = full_reg;
    assign sts.last  = (rd_bump == wr_ptr_reg);
    assign sts.head  = words_reg[rd_ptr_reg];

endmodule

[rtl/dual_cpu_mailbox_fifo.sv]
`timescale 1ns / 1ps
// A word accepted on req sits in the input register; its result word moves on to the
// result register and shows on rsp; both registers hold while rsp is stalled.
// Throughput: one access per cycle while rsp is not stalled; each access touches flags,
// pointers and one FIFO word (a whole FIFO on clear) in one pass between the registers.
// Reset (rst_n low, asynchronous): both FIFOs empty with all words zero, all enables,
// error bits and sync nibbles cleared, both pipeline stages empty.

module dual_cpu_mailbox_fifo (
    input  logic      clk,
    input  logic      rst_n,
    dcmf_req_if.sink  req,
    dcmf_rsp_if.source rsp
);

    // Pipeline registers
    logic              in_valid_reg;
    dcmf_pkg::req_t    in_reg;
    logic              out_valid_reg;
    dcmf_pkg::rsp_t    out_reg;

    // Per-side control registers
    logic [1:0]        en_reg,   en_next;
    logic [1:0]        err_reg,  err_next;
    logic [1:0]        sie_reg,  sie_next;
    logic [1:0]        rie_reg,  rie_next;
    logic [1:0]        sen_reg,  sen_next;
    logic [dcmf_pkg::NIBBLE_W-1:0] nib0_reg, nib0_next;
    logic [dcmf_pkg::NIBBLE_W-1:0] nib1_reg, nib1_next;

    dcmf_pkg::fifo_ctl_t ctl0, ctl1, ctl_me, ctl_peer;
    dcmf_pkg::fifo_sts_t sts0, sts1, sts_me, sts_peer;
    dcmf_pkg::rsp_t      rsp_calc;

    logic              advance;
    logic              fire;
    logic              me;
    logic              peer;
    logic [dcmf_pkg::DATA_W-1:0] wd;
    logic [dcmf_pkg::NIBBLE_W-1:0] nib_me, nib_peer;

    // Handshake: move the input stage whenever the result register frees up
    assign advance   = !out_valid_reg || rsp.ready;
    assign fire      = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;

    assign me       = in_reg.cpu_side;
    assign peer     = ~in_reg.cpu_side;
    assign wd       = in_reg.write_data;
    assign sts_me   = me ? sts1 : sts0;
    assign sts_peer = me ? sts0 : sts1;
    assign nib_me   = me ? nib1_reg : nib0_reg;
    assign nib_peer = me ? nib0_reg : nib1_reg;
    assign ctl0     = me ? ctl_peer : ctl_me;
    assign ctl1     = me ? ctl_me : ctl_peer;

    // Send FIFOs, one per side
    dcmf_fifo u_fifo0 (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl0),
        .sts   (sts0)
    );

    dcmf_fifo u_fifo1 (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl1),
        .sts   (sts1)
    );

    // Decode the access and compute state updates and the result word
    always_comb
    begin
        en_next   = en_reg;
        err_next  = err_reg;
        sie_next  = sie_reg;
        rie_next  = rie_reg;
        sen_next  = sen_reg;
        nib0_next = nib0_reg;
        nib1_next = nib1_reg;
        ctl_me    = '0;
        ctl_peer  = '0;
        rsp_calc  = '0;
        ctl_me.data = dcmf_pkg::to_word(wd);

        if (fire)
        begin
            unique case (dcmf_pkg::op_t'(in_reg.opcode))
                dcmf_pkg::OP_RD_CTRL:
                begin
                    rsp_calc.read_data[dcmf_pkg::CTL_ENABLE]     = en_reg[me];
                    rsp_calc.read_data[dcmf_pkg::CTL_ERROR]      = err_reg[me];
                    rsp_calc.read_data[dcmf_pkg::CTL_RECV_IE]    = rie_reg[me];
                    rsp_calc.read_data[dcmf_pkg::CTL_PEER_FULL]  = sts_peer.full;
                    rsp_calc.read_data[dcmf_pkg::CTL_PEER_EMPTY] = sts_peer.empty;
                    rsp_calc.read_data[dcmf_pkg::CTL_SENT_IE]    = sie_reg[me];
                    rsp_calc.read_data[dcmf_pkg::CTL_OWN_FULL]   = sts_me.full;
                    rsp_calc.read_data[dcmf_pkg::CTL_OWN_EMPTY]  = sts_me.empty;
                end
                dcmf_pkg::OP_WR_CTRL:
                begin
                    if (in_reg.lane_mask[dcmf_pkg::LANE_LO])
                    begin
                        sie_next[me] = wd[dcmf_pkg::CTL_SENT_IE];
                        ctl_me.clear = wd[dcmf_pkg::CTL_CLEAR];
                        // raise sent irq on a rising enable while own FIFO is empty or being cleared
                        if ((wd[dcmf_pkg::CTL_CLEAR] || sts_me.empty)
                            && wd[dcmf_pkg::CTL_SENT_IE] && !sie_reg[me])
                        begin
                            rsp_calc.irq_sent_mask[me] = 1'b1;
                        end
                    end
                    if (in_reg.lane_mask[dcmf_pkg::LANE_HI])
                    begin
                        rie_next[me] = wd[dcmf_pkg::CTL_RECV_IE];
                        en_next[me]  = wd[dcmf_pkg::CTL_ENABLE];
                        if (wd[dcmf_pkg::CTL_ERROR])
                        begin
                            err_next[me] = 1'b0;
                        end
                        // raise recv irq on a rising enable while peer has words
                        if (!sts_peer.empty && wd[dcmf_pkg::CTL_RECV_IE] && !rie_reg[me])
                        begin
                            rsp_calc.irq_recv_mask[me] = 1'b1;
                        end
                    end
                end
                dcmf_pkg::OP_SEND:
                begin
                    if (en_reg[me])
                    begin
                        if (sts_me.full)
                        begin
                            err_next[me] = 1'b1;
                        end
                        else
                        begin
                            ctl_me.push = 1'b1;
                            if (sts_me.empty && rie_reg[peer])
                            begin
                                rsp_calc.irq_recv_mask[peer] = 1'b1;
                            end
                        end
                    end
                end
                dcmf_pkg::OP_RECV:
                begin
                    rsp_calc.read_data = dcmf_pkg::from_word(sts_peer.head);
                    if (en_reg[peer])
                    begin
                        if (sts_peer.empty)
                        begin
                            err_next[me] = 1'b1;
                        end
                        else
                        begin
                            ctl_peer.pop = 1'b1;
                            if (sts_peer.last && sie_reg[peer])
                            begin
                                rsp_calc.irq_sent_mask[peer] = 1'b1;
                            end
                        end
                    end
                end
                dcmf_pkg::OP_RD_SYNC:
                begin
                    rsp_calc.read_data[dcmf_pkg::SYNC_ENABLE] = sen_reg[me];
                    rsp_calc.read_data[dcmf_pkg::SYNC_OWN_LSB +: dcmf_pkg::NIBBLE_W]  = nib_me;
                    rsp_calc.read_data[dcmf_pkg::SYNC_PEER_LSB +: dcmf_pkg::NIBBLE_W] = nib_peer;
                end
                dcmf_pkg::OP_WR_SYNC:
                begin
                    if (in_reg.lane_mask[dcmf_pkg::LANE_HI])
                    begin
                        sen_next[me] = wd[dcmf_pkg::SYNC_ENABLE];
                        if (me)
                        begin
                            nib1_next = wd[dcmf_pkg::SYNC_OWN_LSB +: dcmf_pkg::NIBBLE_W];
                        end
                        else
                        begin
                            nib0_next = wd[dcmf_pkg::SYNC_OWN_LSB +: dcmf_pkg::NIBBLE_W];
                        end
                        if (wd[dcmf_pkg::SYNC_IRQ] && sen_reg[peer])
                        begin
                            rsp_calc.irq_sync_mask[peer] = 1'b1;
                        end
                    end
                end
                default:
                begin
                    // unused codes: no effect, zero result
                end
            endcase
        end
    end

    // Hold per-side control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg   <= '0;
            err_reg  <= '0;
            sie_reg  <= '0;
            rie_reg  <= '0;
            sen_reg  <= '0;
            nib0_reg <= '0;
            nib1_reg <= '0;
        end
        else
        begin
            en_reg   <= en_next;
            err_reg  <= err_next;
            sie_reg  <= sie_next;
            rie_reg  <= rie_next;
            sen_reg  <= sen_next;
            nib0_reg <= nib0_next;
            nib1_reg <= nib1_next;
        end
    end

    // Advance valid bits of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Capture the incoming word and the finished result
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_reg.cpu_side   <= req.cpu_side;
            in_reg.opcode     <= req.opcode;
            in_reg.write_data <= req.write_data;
            in_reg.lane_mask  <= req.lane_mask;
        end
        if (fire)
        begin
            out_reg <= rsp_calc;
        end
    end

    // Drive the result channel
    assign rsp.valid         = out_valid_reg;
    assign rsp.read_data     = out_reg.read_data;
    assign rsp.irq_sent_mask = out_reg.irq_sent_mask;
    assign rsp.irq_recv_mask = out_reg.irq_recv_mask;
    assign rsp.irq_sync_mask = out_reg.irq_sync_mask;

endmodule

[rtl/dcmf_checker.sv]
`timescale 1ns / 1ps

module dcmf_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [dcmf_pkg::DATA_W-1:0] rsp_data,
    input logic [1:0]                  irq_sent,
    input logic [1:0]                  irq_recv,
    input logic [1:0]                  irq_sync
);

    // Hold a stalled result word
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result word dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_data) && $stable(irq_sent)
                                    && $stable(irq_recv) && $stable(irq_sync))
        else $error("result word changed while stalled");

    // One access raises at most one interrupt of each kind
    a_irq_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $onehot0(irq_sent) && $onehot0(irq_recv) && $onehot0(irq_sync))
        else $error("access raised an interrupt for both sides");

    // A rising result valid must go back to an accepted word on req
    a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("result word without a matching accepted word");

endmodule

bind dual_cpu_mailbox_fifo dcmf_checker u_dcmf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.read_data),
    .irq_sent  (rsp.irq_sent_mask),
    .irq_recv  (rsp.irq_recv_mask),
    .irq_sync  (rsp.irq_sync_mask)
);
